### design/sstf_pkg.sv
// ============================================================================
// SSTF scheduler package
// Shared codes for the shortest-seek-time-first request scheduler: status
// codes, input modes, register indexes and the command that steers the cells.
// ============================================================================
package sstf_pkg;

    // Fixed widths of the item fields and registers.
    localparam int REQ_W    = 4;
    localparam int FTRACK_W = 16;
    localparam int CAP_W    = 5;
    localparam int PCOUNT_W = 5;

    // Capacity register value after reset.
    localparam logic [CAP_W-1:0] CAPACITY_RESET = 5'd16;

    // Input item modes.
    localparam logic MODE_SUBMIT   = 1'b0;
    localparam logic MODE_DISPATCH = 1'b1;

    // Register indexes, taken from paddr[2].
    localparam logic REG_CAPACITY    = 1'b0;
    localparam logic REG_START_TRACK = 1'b1;

    // Result status codes.
    typedef enum logic [2:0] {
        ST_ACCEPTED   = 3'd0,
        ST_FULL       = 3'd1,
        ST_DUPLICATE  = 3'd2,
        ST_DISPATCHED = 3'd3,
        ST_EMPTY      = 3'd4
    } t_status;

    // Table update broadcast to every cell.
    typedef enum logic [1:0] {
        OP_NONE,
        OP_LOAD,
        OP_REMOVE
    } t_cell_op;

endpackage

### design/sstf_disk_request_scheduler.sv
// ============================================================================
// SSTF disk request scheduler: an accepted item waits in the scan state while
// the search chain settles, then is closed with a result word; the next word is
// taken only back in idle, after that close. A result left waiting holds the
// close of the next item until it is taken.
// Synchronous reset empties the table, sets capacity 16 and head track 0.
// ============================================================================
module sstf_disk_request_scheduler
    import sstf_pkg::*;
#(
    parameter int DEPTH      = 16,
    parameter int TRACK_BITS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // Configuration port
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    // Input words
    input  logic                i_valid,
    output logic                o_ready,
    input  logic                i_mode,
    input  logic [REQ_W-1:0]    i_requester,
    input  logic [FTRACK_W-1:0] i_track,
    // Result words
    output logic                o_valid,
    input  logic                i_ready,
    output logic [2:0]          o_status,
    output logic [REQ_W-1:0]    o_served_requester,
    output logic [FTRACK_W-1:0] o_served_track,
    output logic [PCOUNT_W-1:0] o_pending_count
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int SW = $clog2(DEPTH + 1);
    localparam int LW = (CW > CAP_W) ? CW : CAP_W;

    typedef enum logic {
        S_IDLE,
        S_SCAN
    } t_state;

    t_state                r_state;
    logic [SW-1:0]         r_wait;
    logic                  r_mode;
    logic [REQ_W-1:0]      r_key_req;
    logic [TRACK_BITS-1:0] r_key_track;
    logic [TRACK_BITS-1:0] r_head;
    logic [CW-1:0]         r_count;
    logic [CAP_W-1:0]      r_capacity;
    logic [FTRACK_W-1:0]   r_start;

    logic                  r_out_valid;
    t_status               r_out_status;
    logic [REQ_W-1:0]      r_out_req;
    logic [FTRACK_W-1:0]   r_out_track;
    logic [PCOUNT_W-1:0]   r_out_count;

    logic                  n_out_valid;
    logic [CW-1:0]         n_count;
    logic [TRACK_BITS-1:0] n_head;

    // Cell entries; index DEPTH is the empty slot above the last cell.
    logic                  w_valid [DEPTH+1];
    logic [REQ_W-1:0]      w_req   [DEPTH+1];
    logic [TRACK_BITS-1:0] w_track [DEPTH+1];

    // Search chain links; index 0 is the seed, index DEPTH the result.
    logic                  ch_found [DEPTH+1];
    logic [TRACK_BITS-1:0] ch_dist  [DEPTH+1];
    logic [IW-1:0]         ch_idx   [DEPTH+1];
    logic [REQ_W-1:0]      ch_req   [DEPTH+1];
    logic [TRACK_BITS-1:0] ch_track [DEPTH+1];
    logic                  ch_dup   [DEPTH+1];

    t_cell_op              w_op;
    t_status               w_status;
    logic                  w_act;
    logic                  w_full;
    logic [LW-1:0]         w_limit;
    logic                  w_cfg_wr;

    assign w_valid[DEPTH] = 1'b0;
    assign w_req[DEPTH]   = '0;
    assign w_track[DEPTH] = '0;

    assign ch_found[0] = 1'b0;
    assign ch_dist[0]  = '0;
    assign ch_idx[0]   = '0;
    assign ch_req[0]   = '0;
    assign ch_track[0] = '0;
    assign ch_dup[0]   = 1'b0;

    // Row of cells, oldest entry in cell zero.
    for (genvar k = 0; k < DEPTH; k++) begin : g_cell
        sstf_cell #(
            .DEPTH      (DEPTH),
            .TRACK_BITS (TRACK_BITS),
            .IDX        (k)
        ) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_op         (w_op),
            .i_load_idx   (r_count),
            .i_remove_idx (ch_idx[DEPTH]),
            .i_load_req   (r_key_req),
            .i_load_track (r_key_track),
            .i_up_valid   (w_valid[k+1]),
            .i_up_req     (w_req[k+1]),
            .i_up_track   (w_track[k+1]),
            .o_valid      (w_valid[k]),
            .o_req        (w_req[k]),
            .o_track      (w_track[k]),
            .i_head       (r_head),
            .i_key_req    (r_key_req),
            .i_found      (ch_found[k]),
            .i_dist       (ch_dist[k]),
            .i_idx        (ch_idx[k]),
            .i_req        (ch_req[k]),
            .i_track      (ch_track[k]),
            .i_dup        (ch_dup[k]),
            .o_found      (ch_found[k+1]),
            .o_dist       (ch_dist[k+1]),
            .o_idx        (ch_idx[k+1]),
            .o_req_best   (ch_req[k+1]),
            .o_track_best (ch_track[k+1]),
            .o_dup        (ch_dup[k+1])
        );
    end

    // Effective limit is the capacity register clipped to the table depth.
    always_comb begin
        if (LW'(r_capacity) > LW'(DEPTH)) begin
            w_limit = LW'(DEPTH);
        end else begin
            w_limit = LW'(r_capacity);
        end
    end

    assign w_full = LW'(r_count) >= w_limit;

    // The chain has settled once the wait count runs out.
    assign w_act = (r_state == S_SCAN) && (r_wait == '0) && (!r_out_valid || i_ready);

    // Decide the outcome of the item and the table update.
    always_comb begin
        w_op     = OP_NONE;
        w_status = ST_EMPTY;
        if (r_mode == MODE_SUBMIT) begin
            if (w_full) begin
                w_status = ST_FULL;
            end else if (ch_dup[DEPTH]) begin
                w_status = ST_DUPLICATE;
            end else begin
                w_status = ST_ACCEPTED;
                w_op     = w_act ? OP_LOAD : OP_NONE;
            end
        end else if (ch_found[DEPTH]) begin
            w_status = ST_DISPATCHED;
            w_op     = w_act ? OP_REMOVE : OP_NONE;
        end
    end

    assign w_cfg_wr = psel && penable && pwrite;

    // Next result flag, pending count and head track; writing the start
    // track also moves the head.
    always_comb begin
        n_out_valid = r_out_valid;
        n_count     = r_count;
        n_head      = r_head;
        if (o_valid && i_ready) begin
            n_out_valid = 1'b0;
        end
        if (w_act) begin
            n_out_valid = 1'b1;
        end
        if (w_op == OP_LOAD) begin
            n_count = r_count + CW'(1);
        end else if (w_op == OP_REMOVE) begin
            n_count = r_count - CW'(1);
            n_head  = ch_track[DEPTH];
        end
        if (w_cfg_wr && (paddr[2] == REG_START_TRACK)) begin
            n_head = TRACK_BITS'(pwdata[FTRACK_W-1:0]);
        end
    end

    // Control state, head track, registers and the result word.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_wait      <= '0;
            r_count     <= '0;
            r_head      <= '0;
            r_capacity  <= CAPACITY_RESET;
            r_start     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            r_count     <= n_count;
            r_head      <= n_head;

            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_state     <= S_SCAN;
                        r_wait      <= SW'(DEPTH);
                        r_mode      <= i_mode;
                        r_key_req   <= i_requester;
                        r_key_track <= TRACK_BITS'(i_track);
                    end
                end
                S_SCAN: begin
                    if (r_wait != '0) begin
                        r_wait <= r_wait - SW'(1);
                    end else if (w_act) begin
                        r_state      <= S_IDLE;
                        r_out_status <= w_status;
                        r_out_req    <= (w_op == OP_REMOVE) ? ch_req[DEPTH] : '0;
                        r_out_track  <= (w_op == OP_REMOVE) ? FTRACK_W'(ch_track[DEPTH])
                                                            : FTRACK_W'(r_head);
                        r_out_count  <= PCOUNT_W'(n_count);
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase

            // Register writes.
            if (w_cfg_wr) begin
                unique case (paddr[2])
                    REG_CAPACITY: begin
                        r_capacity <= pwdata[CAP_W-1:0];
                    end
                    REG_START_TRACK: begin
                        r_start <= pwdata[FTRACK_W-1:0];
                    end
                endcase
            end
        end
    end

    // Register read-back.
    assign prdata = (paddr[2] == REG_START_TRACK) ? 32'(r_start) : 32'(r_capacity);
    assign pready = 1'b1;

    assign o_ready            = (r_state == S_IDLE);
    assign o_valid            = r_out_valid;
    assign o_status           = r_out_status;
    assign o_served_requester = r_out_req;
    assign o_served_track     = r_out_track;
    assign o_pending_count    = r_out_count;

endmodule

### design/sstf_cell.sv
// ============================================================================
// SSTF table cell
// Holds one pending request and forms one link of two compare chains: the
// nearest-track search and the duplicate-requester search. Entries are kept
// in arrival order, so on removal the cell at the hole and each cell above it
// take their upper neighbor's entry.
// ============================================================================
module sstf_cell
    import sstf_pkg::*;
#(
    parameter int DEPTH      = 16,
    parameter int TRACK_BITS = 16,
    parameter int IDX        = 0,
    localparam int CW = $clog2(DEPTH + 1),
    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Table update
    input  t_cell_op              i_op,
    input  logic [CW-1:0]         i_load_idx,
    input  logic [IW-1:0]         i_remove_idx,
    input  logic [REQ_W-1:0]      i_load_req,
    input  logic [TRACK_BITS-1:0] i_load_track,
    // Entry of the upper neighbor, and this cell's entry
    input  logic                  i_up_valid,
    input  logic [REQ_W-1:0]      i_up_req,
    input  logic [TRACK_BITS-1:0] i_up_track,
    output logic                  o_valid,
    output logic [REQ_W-1:0]      o_req,
    output logic [TRACK_BITS-1:0] o_track,
    // Search keys
    input  logic [TRACK_BITS-1:0] i_head,
    input  logic [REQ_W-1:0]      i_key_req,
    // Search chain from the older neighbor
    input  logic                  i_found,
    input  logic [TRACK_BITS-1:0] i_dist,
    input  logic [IW-1:0]         i_idx,
    input  logic [REQ_W-1:0]      i_req,
    input  logic [TRACK_BITS-1:0] i_track,
    input  logic                  i_dup,
    // Search chain to the younger neighbor
    output logic                  o_found,
    output logic [TRACK_BITS-1:0] o_dist,
    output logic [IW-1:0]         o_idx,
    output logic [REQ_W-1:0]      o_req_best,
    output logic [TRACK_BITS-1:0] o_track_best,
    output logic                  o_dup
);

    logic                  r_valid;
    logic [REQ_W-1:0]      r_req;
    logic [TRACK_BITS-1:0] r_track;

    logic                  r_found;
    logic [TRACK_BITS-1:0] r_dist;
    logic [IW-1:0]         r_idx;
    logic [REQ_W-1:0]      r_best_req;
    logic [TRACK_BITS-1:0] r_best_track;
    logic                  r_dup;

    logic                  w_load;
    logic                  w_shift;
    logic [TRACK_BITS-1:0] w_own_dist;
    logic                  w_take;

    assign w_load  = (i_op == OP_LOAD) && (i_load_idx == CW'(IDX));
    assign w_shift = (i_op == OP_REMOVE) && (IW'(IDX) >= i_remove_idx);

    // Seek distance from the head to this entry's track.
    assign w_own_dist = (r_track >= i_head) ? (r_track - i_head) : (i_head - r_track);

    // Strictly nearer wins; on a tie the older entry already in the chain stays.
    assign w_take = r_valid && (!i_found || (w_own_dist < i_dist));

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_load) begin
            r_valid <= 1'b1;
            r_req   <= i_load_req;
            r_track <= i_load_track;
        end else if (w_shift) begin
            r_valid <= i_up_valid;
            r_req   <= i_up_req;
            r_track <= i_up_track;
        end
    end

    // One stage of each search chain.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found <= 1'b0;
            r_dup   <= 1'b0;
        end else begin
            r_dup <= i_dup || (r_valid && (r_req == i_key_req));
            if (w_take) begin
                r_found      <= 1'b1;
                r_dist       <= w_own_dist;
                r_idx        <= IW'(IDX);
                r_best_req   <= r_req;
                r_best_track <= r_track;
            end else begin
                r_found      <= i_found;
                r_dist       <= i_dist;
                r_idx        <= i_idx;
                r_best_req   <= i_req;
                r_best_track <= i_track;
            end
        end
    end

    assign o_valid      = r_valid;
    assign o_req        = r_req;
    assign o_track      = r_track;
    assign o_found      = r_found;
    assign o_dist       = r_dist;
    assign o_idx        = r_idx;
    assign o_req_best   = r_best_req;
    assign o_track_best = r_best_track;
    assign o_dup        = r_dup;

endmodule

### design/sstf_checker.sv
// ============================================================================
// SSTF scheduler port checker
// Watches the top level's ports for handshake and result consistency.
// ============================================================================
module sstf_checker
    import sstf_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  logic                o_ready,
    input  logic                o_valid,
    input  logic                i_ready,
    input  logic [2:0]          o_status,
    input  logic [REQ_W-1:0]    o_served_requester,
    input  logic [PCOUNT_W-1:0] o_pending_count
);

    // One word at a time: input is closed right after an acceptance.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("input accepted while a word was still in work");

    // Only a dispatch names a requester.
    a_requester_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status != ST_DISPATCHED)) |-> (o_served_requester == '0))
        else $error("served requester set on a non-dispatch result");

    // An empty dispatch leaves nothing pending; an accepted submit leaves something.
    a_count_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status == ST_EMPTY)) |-> (o_pending_count == '0))
        else $error("empty result with pending entries");

    a_accept_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status == ST_ACCEPTED)) |-> (o_pending_count != '0))
        else $error("accepted submit with no pending entries");

    // A stalled result holds.
    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_status)))
        else $error("stalled result changed");

endmodule

bind sstf_disk_request_scheduler sstf_checker u_checker (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .i_valid            (i_valid),
    .o_ready            (o_ready),
    .o_valid            (o_valid),
    .i_ready            (i_ready),
    .o_status           (o_status),
    .o_served_requester (o_served_requester),
    .o_pending_count    (o_pending_count)
);

### tb/sv/tb.sv
// ============================================================================
// SSTF disk request scheduler testbench
// Drives submit and dispatch words into the scheduler, models the pending
// table, the seek choice and the head position on its own side, and compares
// every result word field by field with the oldest outstanding prediction.
// ============================================================================
module tb;
    import sstf_pkg::*;

    localparam int TABLE_DEPTH     = 16;
    localparam int SETTLE_CYCLES   = 24;
    localparam int STALL_LIMIT     = 3000;
    localparam int HOLD_CYCLES     = 400;
    localparam int PHASES          = 10;
    localparam int ITEMS_PER_PHASE = 113;

    // One predicted result word.
    typedef struct {
        t_status              status;
        logic [REQ_W-1:0]     requester;
        logic [FTRACK_W-1:0]  track;
        logic [PCOUNT_W-1:0]  count;
    } t_seek_word;

    // Scoreboard: keeps its own copy of the request table and head position.
    class t_seek_scoreboard;
        bit                  busy [TABLE_DEPTH];
        logic [REQ_W-1:0]    owner [TABLE_DEPTH];
        logic [FTRACK_W-1:0] slot_track [TABLE_DEPTH];
        int                  rank [TABLE_DEPTH];
        logic [FTRACK_W-1:0] head;
        logic [CAP_W-1:0]    capacity;
        t_seek_word          outcome_q [$];
        int                  errors;

        function void clear();
            for (int i = 0; i < TABLE_DEPTH; i++) begin
                busy[i] = 1'b0;
                owner[i] = '0;
                slot_track[i] = '0;
                rank[i] = 0;
            end
            head = '0;
            capacity = CAPACITY_RESET;
            outcome_q.delete();
            errors = 0;
        endfunction

        function void write_register(logic idx, logic [31:0] data);
            if (idx == REG_CAPACITY) begin
                capacity = data[CAP_W-1:0];
            end else begin
                // Writing the start track moves the head at once.
                head = data[FTRACK_W-1:0];
            end
        endfunction

        function int occupancy();
            int n;
            n = 0;
            for (int i = 0; i < TABLE_DEPTH; i++)
                if (busy[i])
                    n++;
            return n;
        endfunction

        function void flag(string msg);
            errors++;
            if (errors <= 10)
                $display("mismatch: %s", msg);
        endfunction

        // Apply one accepted word to the table and queue the result it causes.
        function void serve_request(logic m, logic [REQ_W-1:0] r, logic [FTRACK_W-1:0] t);
            t_seek_word res;
            int         pending;
            int         limit;
            int         free_slot;
            int         best;
            int         best_d;
            int         a;
            int         b;
            int         d;
            bit         dup;
            pending = occupancy();
            limit = (capacity > TABLE_DEPTH) ? TABLE_DEPTH : int'(capacity);
            res.requester = '0;
            if (m == MODE_SUBMIT) begin
                dup = 1'b0;
                free_slot = -1;
                for (int i = 0; i < TABLE_DEPTH; i++) begin
                    if (busy[i] && owner[i] == r)
                        dup = 1'b1;
                    if (!busy[i] && free_slot < 0)
                        free_slot = i;
                end
                // Full wins over duplicate when both hold.
                if (pending >= limit || free_slot < 0) begin
                    res.status = ST_FULL;
                end else if (dup) begin
                    res.status = ST_DUPLICATE;
                end else begin
                    busy[free_slot] = 1'b1;
                    owner[free_slot] = r;
                    slot_track[free_slot] = t;
                    rank[free_slot] = pending;
                    pending++;
                    res.status = ST_ACCEPTED;
                end
            end else begin
                // Nearest track to the head; equal distance goes to the oldest.
                best = -1;
                best_d = 0;
                b = int'(head);
                for (int i = 0; i < TABLE_DEPTH; i++) begin
                    if (busy[i]) begin
                        a = int'(slot_track[i]);
                        d = (a >= b) ? a - b : b - a;
                        if (best < 0 || d < best_d || (d == best_d && rank[i] < rank[best])) begin
                            best = i;
                            best_d = d;
                        end
                    end
                end
                if (best < 0) begin
                    res.status = ST_EMPTY;
                end else begin
                    busy[best] = 1'b0;
                    for (int i = 0; i < TABLE_DEPTH; i++)
                        if (busy[i] && rank[i] > rank[best])
                            rank[i]--;
                    head = slot_track[best];
                    res.requester = owner[best];
                    pending--;
                    res.status = ST_DISPATCHED;
                end
            end
            res.track = head;
            res.count = pending[PCOUNT_W-1:0];
            outcome_q = {outcome_q, res};
        endfunction

        // Compare one result word with the oldest prediction.
        function void match_outcome(logic [2:0] st, logic [REQ_W-1:0] r,
                                    logic [FTRACK_W-1:0] t, logic [PCOUNT_W-1:0] c);
            t_seek_word want;
            if (outcome_q.size() == 0) begin
                flag($sformatf("unexpected word status %0d req %0d track %0d count %0d",
                               st, r, t, c));
                return;
            end
            want = outcome_q.pop_front();
            if (st !== want.status || r !== want.requester || t !== want.track ||
                c !== want.count)
                flag($sformatf("expected %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d",
                               want.status, want.requester, want.track, want.count,
                               st, r, t, c));
        endfunction

        function void close_out();
            if (outcome_q.size() != 0)
                flag($sformatf("%0d result words never arrived", outcome_q.size()));
        endfunction
    endclass

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [2:0]          paddr;
    logic [31:0]         pwdata;
    logic [31:0]         prdata;
    logic                pready;
    logic                i_valid;
    logic                o_ready;
    logic                i_mode;
    logic [REQ_W-1:0]    i_requester;
    logic [FTRACK_W-1:0] i_track;
    logic                o_valid;
    logic                i_ready;
    logic [2:0]          o_status;
    logic [REQ_W-1:0]    o_served_requester;
    logic [FTRACK_W-1:0] o_served_track;
    logic [PCOUNT_W-1:0] o_pending_count;

    t_seek_scoreboard board;
    bit quiet_in;
    bit quiet_out;
    bit hold_request;
    int hold_left;

    sstf_disk_request_scheduler uut (.*);

    // Clock with a period of 8.
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Offer one word and wait until the scheduler takes it.
    task automatic send_word(input logic m, input logic [REQ_W-1:0] r,
                             input logic [FTRACK_W-1:0] t);
        while (!quiet_in && $urandom_range(99) < 15) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_mode <= m;
        i_requester <= r;
        i_track <= t;
        @(posedge i_clk);
        while (!o_ready)
            @(posedge i_clk);
        board.serve_request(m, r, t);
    endtask

    task automatic submit(input logic [REQ_W-1:0] r, input logic [FTRACK_W-1:0] t);
        send_word(MODE_SUBMIT, r, t);
    endtask

    // Requester and track are don't-care on a dispatch, so they get noise.
    task automatic dispatch();
        send_word(MODE_DISPATCH, REQ_W'($urandom_range(0, 15)),
                  FTRACK_W'($urandom_range(0, 65535)));
    endtask

    // Stop offering and wait until every predicted word has come back.
    task automatic wait_drained();
        i_valid <= 1'b0;
        while (board.outcome_q.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Register write: setup cycle, then access cycle.
    task automatic write_reg(input logic idx, input logic [31:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready)
            @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        board.write_register(idx, data);
        @(posedge i_clk);
    endtask

    task automatic set_phase(input logic [CAP_W-1:0] cap, input logic [FTRACK_W-1:0] start_pos);
        wait_drained();
        write_reg(REG_CAPACITY, 32'(cap));
        write_reg(REG_START_TRACK, 32'(start_pos));
    endtask

    // Tracks lean toward ties, extremes and the neighborhood of the head.
    function automatic logic [FTRACK_W-1:0] pick_track();
        int roll;
        int x;
        int picks [$];
        roll = $urandom_range(99);
        if (roll < 8)
            return '0;
        if (roll < 16)
            return '1;
        if (roll < 40) begin
            x = int'(board.head) + int'($urandom_range(0, 16)) - 8;
            if (x >= 0 && x <= 65535)
                return x[FTRACK_W-1:0];
        end
        for (int i = 0; i < TABLE_DEPTH; i++)
            if (board.busy[i])
                picks = {picks, i};
        if (roll < 70 && picks.size() != 0) begin
            x = int'(board.slot_track[picks[$urandom_range(0, picks.size() - 1)]]);
            if (roll < 55)
                return x[FTRACK_W-1:0];
            // Mirror around the head: same distance on the other side.
            x = 2 * int'(board.head) - x;
            if (x >= 0 && x <= 65535)
                return x[FTRACK_W-1:0];
        end
        return FTRACK_W'($urandom_range(0, 65535));
    endfunction

    task automatic offer_random(input int submit_pct);
        logic m;
        if (board.occupancy() == 0)
            m = ($urandom_range(99) < 90) ? MODE_SUBMIT : MODE_DISPATCH;
        else
            m = ($urandom_range(99) < submit_pct) ? MODE_SUBMIT : MODE_DISPATCH;
        send_word(m, REQ_W'($urandom_range(0, 15)), pick_track());
    endtask

    // Result side: check each word taken, then pick the next ready.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && i_ready)
                board.match_outcome(o_status, o_served_requester, o_served_track,
                                    o_pending_count);
            if (hold_left > 0) begin
                hold_left--;
                i_ready <= 1'b0;
            end else if (hold_request) begin
                hold_request = 1'b0;
                hold_left = HOLD_CYCLES;
                i_ready <= 1'b0;
            end else begin
                i_ready <= quiet_out || ($urandom_range(99) >= 15);
            end
        end
    end

    // Watchdog on cycles in which no word moves on either side.
    initial begin : watchdog
        int stall_cycles;
        stall_cycles = 0;
        while (stall_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready))
                stall_cycles = 0;
            else
                stall_cycles++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin : main
        logic [CAP_W-1:0]    cap_plan [PHASES];
        logic [FTRACK_W-1:0] head_start;
        int                  p;
        int                  k;
        cap_plan = '{5'd16, 5'd31, 5'd1, 5'd5, 5'd16, 5'd0, 5'd17, 5'd11, 5'd16, 5'd2};
        i_rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        i_valid = 1'b0;
        i_mode = MODE_SUBMIT;
        i_requester = '0;
        i_track = '0;
        i_ready = 1'b0;
        quiet_in = 1'b0;
        quiet_out = 1'b0;
        hold_request = 1'b0;
        hold_left = 0;
        board = new();
        board.clear();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings: empty dispatch, duplicates, equal-track and
        // equal-distance ties, both ends of the track range.
        dispatch();
        submit(4'd0, 16'd0);
        submit(4'd15, 16'hFFFF);
        submit(4'd5, 16'd100);
        submit(4'd5, 16'd200);
        submit(4'd7, 16'd100);
        dispatch();
        dispatch();
        dispatch();
        submit(4'd1, 16'd50);
        submit(4'd2, 16'd150);
        dispatch();

        // Capacity zero rejects every submit; head starts at the top track.
        set_phase(5'd0, 16'hFFFF);
        submit(4'd9, 16'd9);
        dispatch();
        dispatch();
        dispatch();

        // Capacity one: full and duplicate at once reports full.
        set_phase(5'd1, 16'h8000);
        submit(4'd4, 16'd7);
        submit(4'd4, 16'd8);
        submit(4'd6, 16'd9);
        dispatch();
        dispatch();

        // Random phases over a spread of capacities and head positions.
        for (p = 0; p < PHASES; p++) begin
            if (p == 0)
                head_start = '0;
            else if (p == 1)
                head_start = '1;
            else
                head_start = FTRACK_W'($urandom_range(0, 65535));
            set_phase(cap_plan[p], head_start);
            quiet_in = (p == 3);
            quiet_out = (p == 3);
            for (k = 0; k < ITEMS_PER_PHASE; k++) begin
                if (p == 4 && k == 30)
                    hold_request = 1'b1;
                if (p == 7 && k == 57)
                    wait_drained();
                offer_random((p % 2 == 1) ? 75 : 55);
            end
        end

        wait_drained();
        board.close_out();
        if (board.errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
